FILE: src/fifo_queue_with_search_defines.svh
// ---------------------------------------------------------------------------
// fifo_queue_with_search_defines.svh
// Assertion macros shared by the searchable queue RTL.
// ---------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fqs_pkg.sv
// ---------------------------------------------------------------------------
// fqs_pkg
// Sizes, operation codes and result status codes of the searchable queue.
// ---------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CNT_OUT_W = 5;

  localparam int FUNC_W = 2;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [FUNC_W-1:0] OP_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] OP_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_FIND = 2'd2;
  localparam logic [FUNC_W-1:0] OP_SIZE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  function automatic idx_t ring_next(input idx_t idx);
    ring_next = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + idx_t'(1);
  endfunction

endpackage

FILE: src/fifo_queue_with_search.sv
// ---------------------------------------------------------------------------
// fifo_queue_with_search
// First-in first-out queue of 32-bit words in a ring memory, with push,
// pop, find (scan for a matching stored word) and size operations.
// ---------------------------------------------------------------------------
//  channel | ports      | contents
//  --------+------------+---------------------------------------------------
//  input   | in_t*      | tuser: func; tdata: value_in
//  result  | out_t*     | tuser: status; tdata: data_out, found, entry_count
//
//  Push, size and a pop on an empty queue load the output register
//  directly; a pop first reads the head word from memory (S_POP). A find
//  walks the stored entries one memory read a cycle from the head and
//  stops on a hit; on an empty queue it answers at once. One transaction
//  is in flight at a time. A result waits in the output register; a new
//  transaction is taken when it is empty or drains in the same cycle.
//  Synchronous active-low reset clears the pointers and the count; the
//  memory is not cleared.
// ---------------------------------------------------------------------------
`include "fifo_queue_with_search_defines.svh"

module fifo_queue_with_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fqs_pkg::FUNC_W-1:0]        in_tuser,   // [1:0] func
  input  logic [fqs_pkg::WORD_W-1:0]        in_tdata,   // [31:0] value_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fqs_pkg::STAT_W-1:0]        out_tuser,  // [1:0] status
  output logic [fqs_pkg::OUT_TDATA_W-1:0]   out_tdata   // [31:0] data_out,
                                                        // [32] found,
                                                        // [37:33] entry_count,
                                                        // [39:38] zero
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [fqs_pkg::WORD_W-1:0] mem [fqs_pkg::DEPTH];

  logic [1:0]                 state_r, state_nxt;
  fqs_pkg::idx_t              head_r, head_nxt;
  fqs_pkg::idx_t              tail_r, tail_nxt;
  fqs_pkg::cnt_t              fill_r, fill_nxt;
  fqs_pkg::idx_t              scan_addr_r, scan_addr_nxt;
  fqs_pkg::cnt_t              scan_left_r, scan_left_nxt;
  logic [fqs_pkg::WORD_W-1:0] key_r, key_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [fqs_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [fqs_pkg::WORD_W-1:0] out_data_r, out_data_nxt;
  logic                       out_found_r, out_found_nxt;
  fqs_pkg::cnt_t              out_count_r, out_count_nxt;

  fqs_pkg::idx_t              rd_addr;
  logic [fqs_pkg::WORD_W-1:0] rd_data_r;
  logic                       wr_en;
  logic                       in_acc;
  logic                       is_empty;
  logic                       is_full;
  logic [fqs_pkg::CNT_W+fqs_pkg::CNT_OUT_W-1:0] count_ext;

  assign is_empty  = (fill_r == '0);
  assign is_full   = (fill_r == fqs_pkg::CNT_W'(fqs_pkg::DEPTH));
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (in_tuser == fqs_pkg::OP_PUSH) && !is_full;

  // Read the head on a pop or the first find probe, else the next scan slot
  assign rd_addr = (state_r == S_FIND) ? scan_addr_r : head_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    scan_addr_nxt  = scan_addr_r;
    scan_left_nxt  = scan_left_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_status_nxt = fqs_pkg::ST_OK;
          out_data_nxt   = '0;
          out_found_nxt  = 1'b0;
          out_count_nxt  = fill_r;
          unique case (in_tuser)
            fqs_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = fqs_pkg::ST_FULL;
              end else begin
                tail_nxt      = fqs_pkg::ring_next(tail_r);
                fill_nxt      = fill_r + fqs_pkg::cnt_t'(1);
                out_count_nxt = fill_r + fqs_pkg::cnt_t'(1);
              end
            end
            fqs_pkg::OP_POP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fqs_pkg::ST_EMPTY;
              end else begin
                // Commit the pointer now, deliver the word with the read data
                head_nxt  = fqs_pkg::ring_next(head_r);
                fill_nxt  = fill_r - fqs_pkg::cnt_t'(1);
                state_nxt = S_POP;
              end
            end
            fqs_pkg::OP_FIND: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                key_nxt       = in_tdata;
                scan_addr_nxt = fqs_pkg::ring_next(head_r);
                scan_left_nxt = fill_r;
                state_nxt     = S_FIND;
              end
            end
            fqs_pkg::OP_SIZE: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_data_r;
        out_count_nxt = fill_r;
        state_nxt     = S_IDLE;
      end
      S_FIND: begin
        if (rd_data_r == key_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (scan_left_r == fqs_pkg::cnt_t'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          scan_addr_nxt = fqs_pkg::ring_next(scan_addr_r);
          scan_left_nxt = scan_left_r - fqs_pkg::cnt_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    scan_left_r  <= scan_left_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign count_ext  = {{fqs_pkg::CNT_OUT_W{1'b0}}, out_count_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, count_ext[fqs_pkg::CNT_OUT_W-1:0], out_found_r, out_data_r};

  `FQS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= fqs_pkg::CNT_W'(fqs_pkg::DEPTH), "fill count above depth")
  `FQS_ASSERT_NOW(a_ring_empty, fill_r == '0, head_r == tail_r, "empty ring with head and tail apart")
  `FQS_ASSERT_NEXT(a_pop_dec, in_acc && in_tuser == fqs_pkg::OP_POP && fill_r != '0, fill_r == $past(fill_r) - fqs_pkg::cnt_t'(1), "pop did not drop the fill count")
  `FQS_ASSERT_NEXT(a_find_stable, state_r == S_FIND, $stable(fill_r) && $stable(head_r), "queue moved during a search")

endmodule

FILE: test/fifo_queue_with_search_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fifo_queue_with_search_tb
// Drives push, pop, find and size transactions into the searchable queue and
// compares every result with a behavioral ring-buffer predictor or the typed
// row's expected value. A short directed table covers empty and full edges,
// then random traffic runs through several sender and receiver idling phases.
// ---------------------------------------------------------------------------
module fifo_queue_with_search_tb;
  import fqs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 48;
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [WORD_W-1:0]    word;
    logic                 hit;
    logic [CNT_OUT_W-1:0] count;
  } queue_result_t;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [WORD_W-1:0] word;
    bit                typed;
    queue_result_t     want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [FUNC_W-1:0] in_tuser = '0;        // [1:0] func
  logic [WORD_W-1:0] in_tdata = '0;        // [31:0] value_in
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [STAT_W-1:0] out_tuser;            // [1:0] status
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] data_out, [32] found,
                                           // [37:33] entry_count, [39:38] zero

  // predictor state
  logic [WORD_W-1:0] ring_mem [DEPTH];
  int rd_ptr = 0;
  int wr_ptr = 0;
  int occupancy = 0;

  queue_result_t pending_results[$];
  op_row_t directed_ops[$];
  queue_result_t got_result;
  queue_result_t want_result;

  int error_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  fifo_queue_with_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fifo_queue_with_search_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Apply one operation to the shadow ring and return the result it produces.
  function automatic queue_result_t predict_op(input logic [FUNC_W-1:0] op,
                                               input logic [WORD_W-1:0] word);
    queue_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (occupancy == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[wr_ptr] = word;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          occupancy++;
        end
      end
      OP_POP: begin
        if (occupancy == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          occupancy--;
        end
      end
      OP_FIND: begin
        for (int k = 0; k < occupancy; k++)
          if (ring_mem[(rd_ptr + k) % DEPTH] == word) r.hit = 1'b1;
      end
      default: ;
    endcase
    r.count = CNT_OUT_W'(occupancy);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word(input bit for_search);
    int roll;
    roll = $urandom_range(99);
    // favor words already stored so that searches hit and pushes duplicate
    if (occupancy > 0 && roll < (for_search ? 50 : 10))
      return ring_mem[(rd_ptr + $urandom_range(occupancy - 1)) % DEPTH];
    if (roll < 70) return $urandom;
    if (roll < 90) return WORD_W'($urandom_range(7));
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(input int bias);
    int roll;
    int push_w;
    int pop_w;
    roll = $urandom_range(99);
    push_w = (bias == 0) ? 55 : (bias == 1) ? 15 : 35;
    pop_w = (bias == 0) ? 15 : (bias == 1) ? 55 : 35;
    if (roll < push_w) return OP_PUSH;
    if (roll < push_w + pop_w) return OP_POP;
    if (roll < push_w + pop_w + 20) return OP_FIND;
    return OP_SIZE;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word,
                         input bit typed, input logic [STAT_W-1:0] status,
                         input logic [WORD_W-1:0] data, input logic hit,
                         input int count);
    op_row_t row;
    row.op = op;
    row.word = word;
    row.typed = typed;
    row.want = '{status: status, word: data, hit: hit, count: CNT_OUT_W'(count)};
    directed_ops.push_back(row);
  endtask

  // Offer one transaction; record its expected result once it is accepted.
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word,
                         input bit typed, input queue_result_t want);
    queue_result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    predicted = predict_op(op, word);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = '{status: out_tuser, word: out_tdata[31:0], hit: out_tdata[32],
                     count: out_tdata[37:33]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status)
          report_mismatch("status", 40'(got_result.status), 40'(want_result.status));
        if (got_result.word !== want_result.word)
          report_mismatch("data_out", 40'(got_result.word), 40'(want_result.word));
        if (got_result.hit !== want_result.hit)
          report_mismatch("found", 40'(got_result.hit), 40'(want_result.hit));
        if (got_result.count !== want_result.count)
          report_mismatch("entry_count", 40'(got_result.count), 40'(want_result.count));
        if (out_tdata[39:38] !== 2'b00)
          report_mismatch("tdata pad", 40'(out_tdata[39:38]), '0);
      end
    end
  end

  initial begin
    int bias;
    logic [FUNC_W-1:0] op;
    logic [WORD_W-1:0] word;

    // empty-queue edges, then wrap the ring and overfill it
    add_row(OP_SIZE, 32'h0, 1'b1, ST_OK, 32'h0, 1'b0, 0);
    add_row(OP_POP, 32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b0, 0);
    add_row(OP_FIND, 32'h0, 1'b1, ST_OK, 32'h0, 1'b0, 0);
    add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b0, 1);
    add_row(OP_FIND, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 1'b1, 1);
    add_row(OP_FIND, 32'h7FFF_FFFF, 1'b0, ST_OK, 32'h0, 1'b0, 0);
    add_row(OP_POP, 32'h0, 1'b1, ST_OK, 32'hFFFF_FFFF, 1'b0, 0);
    for (int i = 0; i < DEPTH; i++)
      add_row(OP_PUSH, (i == 0) ? 32'h0 : (32'hA5A5_0000 | i), 1'b0, ST_OK, '0, 1'b0, 0);
    add_row(OP_PUSH, 32'h1234_5678, 1'b1, ST_FULL, 32'h0, 1'b0, DEPTH);
    add_row(OP_FIND, 32'h0, 1'b0, ST_OK, '0, 1'b0, 0);
    add_row(OP_SIZE, 32'h0, 1'b1, ST_OK, 32'h0, 1'b0, DEPTH);
    add_row(OP_POP, 32'h0, 1'b0, ST_OK, '0, 1'b0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i])
      send_op(directed_ops[i].op, directed_ops[i].word, directed_ops[i].typed,
              directed_ops[i].want);

    bias = 2;
    for (int phase = 0; phase < 4; phase++) begin
      // hold the sender until the queue of results drains
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 75; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == 20) hold_req = 1'b1;
        if (n % 25 == 0) bias = $urandom_range(2);
        op = pick_op(bias);
        word = pick_word(op == OP_FIND);
        send_op(op, word, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("fifo_queue_with_search_tb: done, clean");
    end else begin
      $display("fifo_queue_with_search_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/fqs_pkg.sv
src/fifo_queue_with_search.sv
test/fifo_queue_with_search_tb.sv
